// ===== hdl/msp_pkg.sv =====
// shared types and constants for the messagepack stream parser
`timescale 1ns / 1ps
package msp_pkg;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam logic [4:0] FIXSTR_MASK = 5'b11111;
  localparam logic [3:0] FIXCNT_MASK = 4'b1111;

  localparam logic [63:0] UINT64_BAD = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [62:0] FLT_POS_LIM = 63'h7FEF_FFFF_FFFF_FFFF;
  localparam logic [62:0] FLT_NEG_LIM = 63'h7FF0_0000_0000_0000;

  // second-byte range classes of a utf-8 sequence
  localparam logic [2:0] RNG_ANY = 3'd0;
  localparam logic [2:0] RNG_E0  = 3'd1;
  localparam logic [2:0] RNG_ED  = 3'd2;
  localparam logic [2:0] RNG_F0  = 3'd3;
  localparam logic [2:0] RNG_F4  = 3'd4;

  typedef enum logic [2:0] {
    CLS_FIXINT = 3'd0,
    CLS_NIL    = 3'd1,
    CLS_BOOL   = 3'd2,
    CLS_FIXMAP = 3'd3,
    CLS_FIXARR = 3'd4,
    CLS_FIXSTR = 3'd5,
    CLS_EXT    = 3'd6,
    CLS_UNSUP  = 3'd7
  } cls_e;

  typedef enum logic [2:0] {
    HDR_UINT   = 3'd0,
    HDR_UINT64 = 3'd1,
    HDR_FLOAT  = 3'd2,
    HDR_STR    = 3'd3,
    HDR_BIN    = 3'd4,
    HDR_ARR    = 3'd5,
    HDR_MAP    = 3'd6
  } hdr_e;

  typedef enum logic [1:0] {
    EV_HDR = 2'd0,
    EV_PAY = 2'd1,
    EV_ERR = 2'd2
  } ev_e;

  typedef enum logic [2:0] {
    KIND_NIL   = 3'd0,
    KIND_BOOL  = 3'd1,
    KIND_INT   = 3'd2,
    KIND_FLOAT = 3'd3,
    KIND_STR   = 3'd4,
    KIND_BIN   = 3'd5,
    KIND_ARR   = 3'd6,
    KIND_MAP   = 3'd7
  } kind_e;

  typedef enum logic [1:0] {
    ERR_CMD   = 2'd0,
    ERR_TRUNC = 2'd1,
    ERR_UTF8  = 2'd2,
    ERR_RANGE = 2'd3
  } err_e;

  typedef enum logic [3:0] {
    PH_CMD  = 4'b0001,
    PH_HDR  = 4'b0010,
    PH_PAY  = 4'b0100,
    PH_SKIP = 4'b1000
  } phase_e;

  // classified input word
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    cls_e       cls;
    hdr_e       hdr;
    logic [3:0] extra;
    logic [1:0] lead_need;
    logic [2:0] lead_rng;
    logic       lead_bad;
    logic [4:0] cont_ok;
  } word_t;

  typedef struct packed {
    ev_e         ev;
    kind_e       kind;
    logic [63:0] value;
    logic [7:0]  pbyte;
    logic        plast;
    err_e        ecode;
  } res_t;

endpackage

// ===== hdl/msp_front.sv =====
// input stage: accepts stream words and classifies each byte
`timescale 1ns / 1ps
module msp_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [7:0]     in_data_i,
  input  logic           in_last_i,
  output logic           push_o,
  input  logic           full_i,
  output msp_pkg::word_t word_o
);
  import msp_pkg::*;

  logic  valid_q;
  word_t word_q;
  word_t word_d;
  logic  accept;

  assign push_o     = valid_q && !full_i;
  assign in_ready_o = !valid_q || !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign word_o     = word_q;

  always_comb begin
    word_d           = '0;
    word_d.data      = in_data_i;
    word_d.last      = in_last_i;
    word_d.cls       = CLS_UNSUP;
    word_d.hdr       = HDR_UINT;
    word_d.extra     = 4'd0;
    // as a command byte
    if (in_data_i <= 8'h7F) begin
      word_d.cls = CLS_FIXINT;
    end else if (in_data_i <= 8'h8F) begin
      word_d.cls = CLS_FIXMAP;
    end else if (in_data_i <= 8'h9F) begin
      word_d.cls = CLS_FIXARR;
    end else if (in_data_i <= 8'hBF) begin
      word_d.cls = CLS_FIXSTR;
    end else if (in_data_i == 8'hC0) begin
      word_d.cls = CLS_NIL;
    end else if (in_data_i inside {8'hC2, 8'hC3}) begin
      word_d.cls = CLS_BOOL;
    end else begin
      word_d.cls = CLS_EXT;
      case (in_data_i)
        8'hCC: begin word_d.hdr = HDR_UINT;   word_d.extra = 4'd1; end
        8'hCD: begin word_d.hdr = HDR_UINT;   word_d.extra = 4'd2; end
        8'hCE: begin word_d.hdr = HDR_UINT;   word_d.extra = 4'd4; end
        8'hCF: begin word_d.hdr = HDR_UINT64; word_d.extra = 4'd8; end
        8'hCB: begin word_d.hdr = HDR_FLOAT;  word_d.extra = 4'd8; end
        8'hD9: begin word_d.hdr = HDR_STR;    word_d.extra = 4'd1; end
        8'hDA: begin word_d.hdr = HDR_STR;    word_d.extra = 4'd2; end
        8'hDB: begin word_d.hdr = HDR_STR;    word_d.extra = 4'd4; end
        8'hC4: begin word_d.hdr = HDR_BIN;    word_d.extra = 4'd1; end
        8'hC5: begin word_d.hdr = HDR_BIN;    word_d.extra = 4'd2; end
        8'hC6: begin word_d.hdr = HDR_BIN;    word_d.extra = 4'd4; end
        8'hDC: begin word_d.hdr = HDR_ARR;    word_d.extra = 4'd2; end
        8'hDD: begin word_d.hdr = HDR_ARR;    word_d.extra = 4'd4; end
        8'hDE: begin word_d.hdr = HDR_MAP;    word_d.extra = 4'd2; end
        8'hDF: begin word_d.hdr = HDR_MAP;    word_d.extra = 4'd4; end
        default: word_d.cls = CLS_UNSUP;
      endcase
    end
    // as a utf-8 lead byte
    word_d.lead_need = 2'd0;
    word_d.lead_rng  = RNG_ANY;
    word_d.lead_bad  = 1'b0;
    if (in_data_i == 8'h00) begin
      word_d.lead_bad = 1'b1;
    end else if (in_data_i <= 8'h7F) begin
      word_d.lead_need = 2'd0;
    end else if (in_data_i inside {[8'hC2:8'hDF]}) begin
      word_d.lead_need = 2'd1;
    end else if (in_data_i == 8'hE0) begin
      word_d.lead_need = 2'd2;
      word_d.lead_rng  = RNG_E0;
    end else if (in_data_i == 8'hED) begin
      word_d.lead_need = 2'd2;
      word_d.lead_rng  = RNG_ED;
    end else if (in_data_i inside {[8'hE1:8'hEF]}) begin
      word_d.lead_need = 2'd2;
    end else if (in_data_i == 8'hF0) begin
      word_d.lead_need = 2'd3;
      word_d.lead_rng  = RNG_F0;
    end else if (in_data_i == 8'hF4) begin
      word_d.lead_need = 2'd3;
      word_d.lead_rng  = RNG_F4;
    end else if (in_data_i inside {[8'hF1:8'hF3]}) begin
      word_d.lead_need = 2'd3;
    end else begin
      word_d.lead_bad = 1'b1;
    end
    // as a continuation byte, one flag per range class
    word_d.cont_ok[0] = in_data_i inside {[8'h80:8'hBF]};
    word_d.cont_ok[1] = in_data_i inside {[8'hA0:8'hBF]};
    word_d.cont_ok[2] = in_data_i inside {[8'h80:8'h9F]};
    word_d.cont_ok[3] = in_data_i inside {[8'h90:8'hBF]};
    word_d.cont_ok[4] = in_data_i inside {[8'h80:8'h8F]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (push_o) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      word_q <= word_d;
    end
  end

endmodule

// ===== hdl/msp_fifo.sv =====
// short queue of classified words between front and back
`timescale 1ns / 1ps
module msp_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  msp_pkg::word_t push_word_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output msp_pkg::word_t head_o
);
  import msp_pkg::*;

  word_t              mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q;
  logic [FIFO_AW-1:0] rd_ptr_q;
  logic [FIFO_CW-1:0] cnt_q;
  logic [FIFO_CW-1:0] cnt_d;

  assign full_o  = (cnt_q == FIFO_CW'(FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_word_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FIFO_CW'(FIFO_DEPTH))
    else $error("queue count above depth");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    FIFO_AW'(wr_ptr_q - rd_ptr_q) == cnt_q[FIFO_AW-1:0])
    else $error("queue pointers disagree with count");

endmodule

// ===== hdl/msp_back.sv =====
// decode engine: runs the parse state per word and holds the result register
`timescale 1ns / 1ps
module msp_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  msp_pkg::word_t word_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output msp_pkg::res_t  res_o
);
  import msp_pkg::*;

  phase_e      phase_q, phase_d;
  hdr_e        hdr_q, hdr_d;
  logic [3:0]  left_q, left_d;
  logic [63:0] acc_q, acc_d;
  logic [31:0] pay_q, pay_d;
  logic        str_q, str_d;
  logic [1:0]  need_q, need_d;
  logic [2:0]  rng_q, rng_d;

  logic        out_valid_q;
  res_t        out_q;
  res_t        res;
  logic        emit;

  logic        fail_en;
  err_e        fail_code;
  logic        sp_en;
  kind_e       sp_kind;
  logic [31:0] sp_len;
  logic [63:0] acc_new;
  logic        flt_bad;
  logic        pay_last;
  logic        utf_ok;
  logic [1:0]  need_n;
  logic [2:0]  rng_n;

  assign pop_o       = !empty_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign res_o       = out_q;

  assign acc_new  = {acc_q[55:0], word_i.data};
  assign flt_bad  = acc_new[63] ? (acc_new[62:0] > FLT_NEG_LIM)
                                : (acc_new[62:0] >= FLT_POS_LIM);
  assign pay_last = (pay_q == 32'd1);

  // utf-8 step for a string payload byte
  always_comb begin
    utf_ok = 1'b1;
    need_n = need_q;
    rng_n  = rng_q;
    if (need_q == 2'd0) begin
      utf_ok = !word_i.lead_bad;
      need_n = word_i.lead_need;
      rng_n  = word_i.lead_rng;
    end else begin
      case (rng_q)
        RNG_ANY: utf_ok = word_i.cont_ok[0];
        RNG_E0:  utf_ok = word_i.cont_ok[1];
        RNG_ED:  utf_ok = word_i.cont_ok[2];
        RNG_F0:  utf_ok = word_i.cont_ok[3];
        RNG_F4:  utf_ok = word_i.cont_ok[4];
        default: utf_ok = 1'b0;
      endcase
      need_n = need_q - 2'd1;
      rng_n  = RNG_ANY;
    end
  end

  always_comb begin
    phase_d   = phase_q;
    hdr_d     = hdr_q;
    left_d    = left_q;
    acc_d     = acc_q;
    pay_d     = pay_q;
    str_d     = str_q;
    need_d    = need_q;
    rng_d     = rng_q;
    emit      = 1'b0;
    fail_en   = 1'b0;
    fail_code = ERR_CMD;
    sp_en     = 1'b0;
    sp_kind   = KIND_STR;
    sp_len    = '0;
    res.ev    = EV_HDR;
    res.kind  = KIND_NIL;
    res.value = '0;
    res.pbyte = '0;
    res.plast = 1'b0;
    res.ecode = ERR_CMD;

    case (phase_q)
      PH_CMD: begin
        case (word_i.cls)
          CLS_FIXINT: begin
            emit      = 1'b1;
            res.kind  = KIND_INT;
            res.value = {56'd0, word_i.data};
          end
          CLS_NIL: begin
            emit = 1'b1;
          end
          CLS_BOOL: begin
            emit      = 1'b1;
            res.kind  = KIND_BOOL;
            res.value = {63'd0, word_i.data[0]};
          end
          CLS_FIXMAP: begin
            emit      = 1'b1;
            res.kind  = KIND_MAP;
            res.value = {60'd0, word_i.data[3:0] & FIXCNT_MASK};
          end
          CLS_FIXARR: begin
            emit      = 1'b1;
            res.kind  = KIND_ARR;
            res.value = {60'd0, word_i.data[3:0] & FIXCNT_MASK};
          end
          CLS_FIXSTR: begin
            sp_en   = 1'b1;
            sp_kind = KIND_STR;
            sp_len  = {27'd0, word_i.data[4:0] & FIXSTR_MASK};
          end
          CLS_EXT: begin
            if (word_i.last) begin
              fail_en   = 1'b1;
              fail_code = ERR_TRUNC;
            end else begin
              hdr_d   = word_i.hdr;
              left_d  = word_i.extra;
              acc_d   = '0;
              phase_d = PH_HDR;
            end
          end
          default: begin
            fail_en   = 1'b1;
            fail_code = ERR_CMD;
          end
        endcase
      end
      PH_HDR: begin
        acc_d  = acc_new;
        left_d = left_q - 4'd1;
        if (left_q == 4'd1) begin
          phase_d = PH_CMD;
          case (hdr_q)
            HDR_UINT: begin
              emit      = 1'b1;
              res.kind  = KIND_INT;
              res.value = acc_new;
            end
            HDR_UINT64: begin
              if (acc_new == UINT64_BAD) begin
                fail_en   = 1'b1;
                fail_code = ERR_RANGE;
              end else begin
                emit      = 1'b1;
                res.kind  = KIND_INT;
                res.value = acc_new;
              end
            end
            HDR_FLOAT: begin
              if (flt_bad) begin
                fail_en   = 1'b1;
                fail_code = ERR_RANGE;
              end else begin
                emit      = 1'b1;
                res.kind  = KIND_FLOAT;
                res.value = acc_new;
              end
            end
            HDR_STR: begin
              sp_en   = 1'b1;
              sp_kind = KIND_STR;
              sp_len  = acc_new[31:0];
            end
            HDR_BIN: begin
              sp_en   = 1'b1;
              sp_kind = KIND_BIN;
              sp_len  = acc_new[31:0];
            end
            HDR_ARR: begin
              emit      = 1'b1;
              res.kind  = KIND_ARR;
              res.value = acc_new;
            end
            default: begin
              emit      = 1'b1;
              res.kind  = KIND_MAP;
              res.value = acc_new;
            end
          endcase
        end else if (word_i.last) begin
          fail_en   = 1'b1;
          fail_code = ERR_TRUNC;
        end
      end
      PH_PAY: begin
        pay_d = pay_q - 32'd1;
        if (!pay_last && word_i.last) begin
          fail_en   = 1'b1;
          fail_code = ERR_TRUNC;
        end else if (str_q && (!utf_ok || (pay_last && need_n != 2'd0))) begin
          fail_en   = 1'b1;
          fail_code = ERR_UTF8;
        end else begin
          emit      = 1'b1;
          res.ev    = EV_PAY;
          res.kind  = str_q ? KIND_STR : KIND_BIN;
          res.pbyte = word_i.data;
          res.plast = pay_last;
          if (str_q) begin
            need_d = need_n;
            rng_d  = rng_n;
          end
          if (pay_last) begin
            phase_d = PH_CMD;
          end
        end
      end
      default: begin
        if (word_i.last) begin
          phase_d = PH_CMD;
        end
      end
    endcase

    // string or binary header
    if (sp_en) begin
      if (sp_len == '0) begin
        emit     = 1'b1;
        res.kind = sp_kind;
        phase_d  = PH_CMD;
      end else if (word_i.last) begin
        fail_en   = 1'b1;
        fail_code = ERR_TRUNC;
      end else begin
        emit      = 1'b1;
        res.kind  = sp_kind;
        res.value = {32'd0, sp_len};
        phase_d   = PH_PAY;
        pay_d     = sp_len;
        str_d     = (sp_kind == KIND_STR);
        need_d    = 2'd0;
        rng_d     = RNG_ANY;
      end
    end

    if (fail_en) begin
      emit      = 1'b1;
      res.ev    = EV_ERR;
      res.kind  = KIND_NIL;
      res.value = '0;
      res.pbyte = '0;
      res.plast = 1'b0;
      res.ecode = fail_code;
      phase_d   = word_i.last ? PH_CMD : PH_SKIP;
      need_d    = 2'd0;
      rng_d     = RNG_ANY;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_CMD;
      hdr_q       <= HDR_UINT;
      left_q      <= '0;
      acc_q       <= '0;
      pay_q       <= '0;
      str_q       <= 1'b0;
      need_q      <= '0;
      rng_q       <= RNG_ANY;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        phase_q <= phase_d;
        hdr_q   <= hdr_d;
        left_q  <= left_d;
        acc_q   <= acc_d;
        pay_q   <= pay_d;
        str_q   <= str_d;
        need_q  <= need_d;
        rng_q   <= rng_d;
      end
      if (pop_o && emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && emit) begin
      out_q <= res;
    end
  end

  a_hdr_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_HDR |-> (left_q != 4'd0 && left_q <= 4'd8))
    else $error("header phase with no bytes left");

  a_pay_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAY |-> pay_q != 32'd0)
    else $error("payload phase with zero length left");

  a_utf_scope: assert property (@(posedge clk_i) disable iff (!rst_ni)
    need_q != 2'd0 |-> (phase_q == PH_PAY && str_q))
    else $error("open utf-8 sequence outside a string payload");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && emit && res.ev == EV_PAY && res.plast) |=> phase_q == PH_CMD)
    else $error("final payload byte did not return to command phase");

endmodule

// ===== hdl/msgpack_stream_parser.sv =====
// top level of the messagepack stream parser
// a result word passes the classify register, the queue and the result register, in that order
// one input word per cycle unless the queue is full; each gives zero or one result word
// the classify stage and a four-word queue let input and output stall independently
// reset: asynchronous, active low; clears all parse state, decoding starts at a command byte
`timescale 1ns / 1ps
module msgpack_stream_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
  input  logic        s_axis_tlast,  // buffer_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,  // [63:0] item_value, [71:64] payload_byte,
                                     // [73:72] error_code, [79:74] zero
  output logic [4:0]  m_axis_tuser,  // [1:0] event_res, [4:2] item_kind
  output logic        m_axis_tlast   // payload_last
);
  import msp_pkg::*;

  logic  push;
  logic  full;
  logic  pop;
  logic  empty;
  word_t push_word;
  word_t head_word;
  res_t  res;

  msp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_data_i  (s_axis_tdata),
    .in_last_i  (s_axis_tlast),
    .push_o     (push),
    .full_i     (full),
    .word_o     (push_word)
  );

  msp_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_word_i (push_word),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .head_o      (head_word)
  );

  msp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .word_i      (head_word),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {6'd0, res.ecode, res.pbyte, res.value};
  assign m_axis_tuser = {res.kind, res.ev};
  assign m_axis_tlast = res.plast;

endmodule
